// ----- rtl/text_console_char_engine_core_assert.svh -----
// Assertion macros for the text console character engine.
// Used by the RTL files that carry concurrent assertions; no dependencies.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCCE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tcce_pkg.sv -----
// Shared types, constants and controller/datapath interface for the text console engine.
// No dependencies.
package tcce_pkg;

    localparam int SCREEN_COLS = 80;
    localparam int SCREEN_ROWS = 25;
    localparam int CELL_COUNT  = SCREEN_COLS * SCREEN_ROWS;
    localparam int COPY_COUNT  = SCREEN_COLS * (SCREEN_ROWS - 2);
    localparam int BLANK_END   = SCREEN_COLS * (SCREEN_ROWS - 1);

    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int COL_W  = $clog2(SCREEN_COLS);
    localparam int ROW_W  = $clog2(SCREEN_ROWS);
    localparam int CELL_W = 16;
    localparam int LOC_W  = 11;
    localparam int TAB_STEP = 8;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] RESET_COLOR = 8'hf0;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  char_code;
        logic [7:0]  color;
        logic [10:0] cell_address;
    } tcce_in_t;

    typedef struct packed {
        logic [10:0] cursor_location;
        logic [7:0]  cell_char;
        logic [7:0]  cell_color;
    } tcce_out_t;

    typedef enum logic [2:0] {
        SW_NONE,
        SW_INIT,
        SW_COPY,
        SW_BLANK,
        SW_CLEAR
    } sweep_t;

    typedef struct packed {
        logic   load_item;
        logic   exec;
        sweep_t sweep;
        logic   load_out;
    } tcce_cmd_t;

    typedef struct packed {
        logic is_put;
        logic is_clear;
        logic scroll;
        logic sweep_last;
    } tcce_status_t;

endpackage

// ----- rtl/tcce_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module tcce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/tcce_ctrl.sv -----
// Controller state machine of the text console engine: handshakes, sweeps, result hand-off.
// Depends on tcce_pkg and text_console_char_engine_core_assert.svh.
`include "text_console_char_engine_core_assert.svh"

module tcce_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    output tcce_pkg::tcce_cmd_t    cmd,
    input  tcce_pkg::tcce_status_t status
);

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_COPY,
        ST_BLANK,
        ST_CLEAR,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic   s_ready_reg;
    logic   m_valid_reg;

    always_comb begin
        cmd           = '0;
        cmd.sweep     = tcce_pkg::SW_NONE;
        case (state_reg)
            ST_INIT:  cmd.sweep = tcce_pkg::SW_INIT;
            ST_IDLE:  cmd.load_item = s_valid && s_ready_reg;
            ST_EXEC:  cmd.exec = 1'b1;
            ST_COPY:  cmd.sweep = tcce_pkg::SW_COPY;
            ST_BLANK: cmd.sweep = tcce_pkg::SW_BLANK;
            ST_CLEAR: cmd.sweep = tcce_pkg::SW_CLEAR;
            ST_DONE:  cmd.load_out = !m_valid_reg || m_ready;
            default:  cmd.sweep = tcce_pkg::SW_NONE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            s_ready_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_INIT: begin
                    if (status.sweep_last) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                ST_IDLE: begin
                    if (cmd.load_item) begin
                        state_reg   <= ST_EXEC;
                        s_ready_reg <= 1'b0;
                    end
                end
                ST_EXEC: begin
                    if (status.is_clear) begin
                        state_reg <= ST_CLEAR;
                    end else if (status.is_put && status.scroll) begin
                        state_reg <= ST_COPY;
                    end else begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_COPY: begin
                    if (status.sweep_last) begin
                        state_reg <= ST_BLANK;
                    end
                end
                ST_BLANK, ST_CLEAR: begin
                    if (status.sweep_last) begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (cmd.load_out) begin
                        state_reg   <= ST_IDLE;
                        s_ready_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg   <= ST_INIT;
                    s_ready_reg <= 1'b0;
                end
            endcase
        end
    end

    assign s_ready = s_ready_reg;
    assign m_valid = m_valid_reg;

    `TCCE_ASSERT_IMP(a_ready_only_idle, aclk, aresetn, s_ready_reg, state_reg == ST_IDLE, "ready outside idle")
    `TCCE_ASSERT_NXT(a_accept_to_exec, aclk, aresetn, (s_valid && s_ready_reg), state_reg == ST_EXEC, "accepted item not executed")
    `TCCE_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.load_out, (!m_valid_reg || m_ready), "result overwritten")
    `TCCE_ASSERT_IMP(a_sweep_blocks_input, aclk, aresetn, (cmd.sweep != tcce_pkg::SW_NONE), !s_ready_reg, "input open during sweep")

endmodule

// ----- rtl/tcce_dp.sv -----
// Datapath of the text console engine: cursor, fill color, sweep counter, screen RAM, result.
// Depends on tcce_pkg and tcce_ram.
module tcce_dp (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  tcce_pkg::tcce_in_t     s_payload,
    output tcce_pkg::tcce_out_t    m_payload,
    input  tcce_pkg::tcce_cmd_t    cmd,
    output tcce_pkg::tcce_status_t status
);

    localparam int AW = tcce_pkg::ADDR_W;
    localparam int CW = tcce_pkg::COL_W;
    localparam int RW = tcce_pkg::ROW_W;
    localparam int LW = tcce_pkg::LOC_W;

    localparam logic [AW-1:0] COLS_A     = AW'(tcce_pkg::SCREEN_COLS);
    localparam logic [AW-1:0] INIT_LAST  = AW'(tcce_pkg::CELL_COUNT - 1);
    localparam logic [AW-1:0] CLEAR_LAST = AW'(tcce_pkg::BLANK_END - 1);
    localparam logic [AW-1:0] COPY_LAST  = AW'(tcce_pkg::COPY_COUNT);
    localparam logic [AW-1:0] BLANK_LAST = AW'(tcce_pkg::BLANK_END);
    localparam logic [CW:0]   COLS_C     = (CW + 1)'(tcce_pkg::SCREEN_COLS);
    localparam logic [CW:0]   TAB_ADD    = (CW + 1)'(tcce_pkg::TAB_STEP);
    localparam logic [CW:0]   TAB_MASK   = ~((CW + 1)'(tcce_pkg::TAB_STEP - 1));
    localparam logic [RW-1:0] SCROLL_ROW = RW'(tcce_pkg::SCREEN_ROWS - 2);

    tcce_pkg::tcce_in_t  item_reg;
    tcce_pkg::tcce_out_t out_reg;
    logic [CW-1:0] col_reg;
    logic [RW-1:0] row_reg;
    logic [7:0]    fill_reg;
    logic [AW-1:0] cnt_reg;

    logic [AW-1:0] cur_lin;
    logic [CW:0]   col_t;
    logic [RW-1:0] row_t;
    logic [CW-1:0] col_next;
    logic [RW-1:0] row_next;
    logic          scroll;
    logic          put_we;
    logic [AW-1:0] put_addr;
    logic [15:0]   put_cell;
    logic          in_range;

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [tcce_pkg::CELL_W-1:0]   ram_wdata;
    logic                          ram_re;
    logic [AW-1:0]                 ram_raddr;
    logic [tcce_pkg::CELL_W-1:0]   ram_rdata;

    assign cur_lin  = AW'(row_reg) * COLS_A + AW'(col_reg);
    assign in_range = 32'(item_reg.cell_address) < 32'(tcce_pkg::CELL_COUNT);

    always_comb begin
        col_t    = {1'b0, col_reg};
        row_t    = row_reg;
        put_we   = 1'b0;
        put_addr = cur_lin;
        put_cell = {item_reg.color, item_reg.char_code};
        case (item_reg.char_code)
            tcce_pkg::CH_BS: begin
                if (col_reg != '0) begin
                    col_t    = {1'b0, col_reg} - (CW + 1)'(1);
                    put_we   = 1'b1;
                    put_addr = cur_lin - AW'(1);
                    put_cell = {item_reg.color, tcce_pkg::CH_BLANK};
                end
            end
            tcce_pkg::CH_TAB: col_t = ({1'b0, col_reg} + TAB_ADD) & TAB_MASK;
            tcce_pkg::CH_CR:  col_t = '0;
            tcce_pkg::CH_LF: begin
                col_t = '0;
                row_t = row_reg + RW'(1);
            end
            default: begin
                put_we = 1'b1;
                col_t  = {1'b0, col_reg} + (CW + 1)'(1);
            end
        endcase
        if (col_t >= COLS_C) begin
            col_t = '0;
            row_t = row_t + RW'(1);
        end
        scroll   = row_t >= SCROLL_ROW;
        col_next = CW'(col_t);
        row_next = scroll ? row_t - RW'(1) : row_t;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg;
        ram_wdata = {fill_reg, tcce_pkg::CH_BLANK};
        ram_re    = 1'b0;
        ram_raddr = cnt_reg + COLS_A;
        case (cmd.sweep)
            tcce_pkg::SW_INIT: begin
                ram_we    = 1'b1;
                ram_wdata = {tcce_pkg::RESET_COLOR, tcce_pkg::CH_BLANK};
            end
            tcce_pkg::SW_CLEAR: ram_we = 1'b1;
            tcce_pkg::SW_COPY: begin
                ram_we    = cnt_reg != '0;
                ram_waddr = cnt_reg - AW'(1);
                ram_wdata = ram_rdata;
                ram_re    = cnt_reg != COPY_LAST;
            end
            tcce_pkg::SW_BLANK: begin
                ram_we    = 1'b1;
                ram_waddr = cnt_reg - AW'(1);
            end
            default: begin
                if (cmd.exec && item_reg.op == tcce_pkg::OP_PUT) begin
                    ram_we    = put_we;
                    ram_waddr = put_addr;
                    ram_wdata = put_cell;
                end
                if (cmd.exec && item_reg.op == tcce_pkg::OP_READ) begin
                    ram_re    = in_range;
                    ram_raddr = AW'(item_reg.cell_address);
                end
            end
        endcase
    end

    always_comb begin
        status.is_put   = item_reg.op == tcce_pkg::OP_PUT;
        status.is_clear = item_reg.op == tcce_pkg::OP_CLEAR;
        status.scroll   = scroll;
        case (cmd.sweep)
            tcce_pkg::SW_INIT:  status.sweep_last = cnt_reg == INIT_LAST;
            tcce_pkg::SW_CLEAR: status.sweep_last = cnt_reg == CLEAR_LAST;
            tcce_pkg::SW_COPY:  status.sweep_last = cnt_reg == COPY_LAST;
            tcce_pkg::SW_BLANK: status.sweep_last = cnt_reg == BLANK_LAST;
            default:            status.sweep_last = 1'b0;
        endcase
    end

    tcce_ram #(
        .WIDTH(tcce_pkg::CELL_W),
        .DEPTH(tcce_pkg::CELL_COUNT)
    ) u_screen (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            fill_reg <= tcce_pkg::RESET_COLOR;
            cnt_reg  <= '0;
        end else begin
            if (cmd.exec) begin
                cnt_reg <= '0;
                if (item_reg.op == tcce_pkg::OP_PUT) begin
                    col_reg <= col_next;
                    row_reg <= row_next;
                end else if (item_reg.op == tcce_pkg::OP_CLEAR) begin
                    col_reg  <= '0;
                    row_reg  <= '0;
                    fill_reg <= item_reg.color;
                end
            end else if (cmd.sweep != tcce_pkg::SW_NONE) begin
                cnt_reg <= cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            item_reg <= s_payload;
        end
        if (cmd.load_out) begin
            out_reg.cursor_location <= LW'(cur_lin);
            if (item_reg.op == tcce_pkg::OP_READ && in_range) begin
                out_reg.cell_char  <= ram_rdata[7:0];
                out_reg.cell_color <= ram_rdata[15:8];
            end else begin
                out_reg.cell_char  <= '0;
                out_reg.cell_color <= '0;
            end
        end
    end

    assign m_payload = out_reg;

endmodule

// ----- rtl/text_console_char_engine_core.sv -----
// Top level of the text console character engine: controller plus datapath.
// Depends on tcce_pkg, tcce_ctrl and tcce_dp.
//
// One item at a time over a valid/ready pair on each side; the result sits in an
// output register, so the next item is taken while it waits. Plain characters,
// control codes, reads and the unused op pass from accept through an execute
// state and a done state, which holds until the output register is free. A put
// that reaches the scroll row then moves COLS*(ROWS-2) cells (1840) up a row and
// blanks the row below; a clear blanks COLS*(ROWS-1) cells (1920). After reset
// a clearing pass over all COLS*ROWS cells (2000) fills the screen before the
// first item is taken. Sweeps use the single RAM write port, one cell a cycle.
module text_console_char_engine_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcce_pkg::tcce_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output tcce_pkg::tcce_out_t m_payload
);

    tcce_pkg::tcce_cmd_t    cmd;
    tcce_pkg::tcce_status_t status;

    tcce_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .cmd    (cmd),
        .status (status)
    );

    tcce_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_payload(s_payload),
        .m_payload(m_payload),
        .cmd      (cmd),
        .status   (status)
    );

endmodule
